// File: src/rmsn_pkg.sv
// rmsn_pkg: shared types and constants of the RMS normalizer.
// Used by rmsn_ctrl, rmsn_dp and rms_normalizer; no dependencies.
`timescale 1ns / 1ps
package rmsn_pkg;
    localparam int MAX_LENGTH  = 4096;
    localparam int LEN_W       = 13;
    localparam int EPS_W       = 16;
    localparam int SAMPLE_W    = 16;
    localparam int SUM_W       = 43;
    localparam int SCALE_W     = 28;
    localparam int MS_W        = 44;
    localparam int DIVD_W      = 59;
    localparam int REM_W       = 45;
    localparam int ROOT_W      = 30;
    localparam int SREM_W      = 32;
    localparam int CNT_W       = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] REG_VECTOR_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EPSILON       = 2'd1;

    localparam logic [LEN_W-1:0]   LEN_RESET   = 13'd4096;
    localparam logic [EPS_W-1:0]   EPS_RESET   = 16'd17;
    localparam logic [SCALE_W-1:0] SCALE_ONE   = 28'd65536;
    localparam logic [SCALE_W-1:0] SCALE_MAX   = {SCALE_W{1'b1}};
    localparam logic [SUM_W-1:0]   SUM_MAX     = {SUM_W{1'b1}};
    localparam logic [CNT_W-1:0]   DIV_STEPS_M1  = 6'd58;
    localparam logic [CNT_W-1:0]   SQRT_STEPS_M1 = 6'd29;

    localparam logic CMD_ACCUM = 1'b0;
    localparam logic CMD_NORM  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_MEAN,
        ST_DIV_MEAN,
        ST_LOAD_RECIP,
        ST_DIV_RECIP,
        ST_LOAD_SQRT,
        ST_SQRT,
        ST_SCALE
    } t_state;

    typedef struct packed {
        logic accum;
        logic norm;
        logic last;
        logic load_mean;
        logic load_recip;
        logic sat_scale;
        logic div_step;
        logic load_sqrt;
        logic sqrt_step;
        logic load_scale;
    } t_cmd;

    typedef struct packed {
        logic ms_zero;
        logic out_free;
    } t_stat;
endpackage

// File: src/rms_normalizer.sv
// rms_normalizer: RMS layer normalization of a streamed Q4.12 vector.
// Accumulate transfers are taken while idle; a normalize transfer also waits for a free output register.
// A normalize result appears in the cycle after its transfer, held in an output register.
// At the end of an accumulate pass the input stalls while the shared
// divider (2 x 59 steps) and the square-root unit (30 steps) form the scale; when the mean
// square is zero the scale saturates and the second division and the square root are skipped.
// Synchronous active-low reset: sums and counts clear, scale 1.0, length 4096, epsilon 17.
`timescale 1ns / 1ps
module rms_normalizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample
    input  logic        s_axis_tuser,   // [0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] norm_value
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [rmsn_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rmsn_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    logic [rmsn_pkg::LEN_W-1:0] r_vlen;
    logic [rmsn_pkg::EPS_W-1:0] r_eps;
    logic [rmsn_pkg::LEN_W-1:0] len_eff;
    rmsn_pkg::t_cmd  cmd;
    rmsn_pkg::t_stat stat;
    logic signed [15:0] out_value;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vlen <= rmsn_pkg::LEN_RESET;
            r_eps  <= rmsn_pkg::EPS_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rmsn_pkg::REG_VECTOR_LENGTH: r_vlen <= i_cfg_data[rmsn_pkg::LEN_W-1:0];
                rmsn_pkg::REG_EPSILON:       r_eps  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_vlen == '0)
            len_eff = 13'd1;
        else if (r_vlen > rmsn_pkg::LEN_W'(rmsn_pkg::MAX_LENGTH))
            len_eff = rmsn_pkg::LEN_W'(rmsn_pkg::MAX_LENGTH);
        else
            len_eff = r_vlen;
    end

    rmsn_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_cmd   (s_axis_tuser),
        .i_len   (len_eff),
        .i_stat  (stat),
        .o_ready (s_axis_tready),
        .o_cmd   (cmd)
    );

    rmsn_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_sample    ($signed(s_axis_tdata)),
        .i_len       (len_eff),
        .i_eps       (r_eps),
        .i_out_ready (m_axis_tready),
        .o_stat      (stat),
        .o_out_valid (m_axis_tvalid),
        .o_out_value (out_value),
        .o_out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = out_value;
endmodule

// File: src/rmsn_ctrl.sv
// rmsn_ctrl: controller of the RMS normalizer; pass counters and the
// sequencer for the scale computation. Depends on rmsn_pkg.
`timescale 1ns / 1ps
module rmsn_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          i_cmd,
    input  logic [rmsn_pkg::LEN_W-1:0]    i_len,
    input  rmsn_pkg::t_stat               i_stat,
    output logic                          o_ready,
    output rmsn_pkg::t_cmd                o_cmd
);
    rmsn_pkg::t_state r_state, n_state;
    logic [rmsn_pkg::LEN_W-1:0] r_acc_cnt, n_acc_cnt;
    logic [rmsn_pkg::LEN_W-1:0] r_norm_cnt, n_norm_cnt;
    logic [rmsn_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic xfer, acc_end, norm_end;

    assign o_ready = (r_state == rmsn_pkg::ST_IDLE) &&
                     ((i_cmd == rmsn_pkg::CMD_ACCUM) || i_stat.out_free);
    assign xfer     = i_valid && o_ready;
    assign acc_end  = ({1'b0, r_acc_cnt} + 14'd1) >= {1'b0, i_len};
    assign norm_end = ({1'b0, r_norm_cnt} + 14'd1) >= {1'b0, i_len};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rmsn_pkg::ST_IDLE: begin
                if (xfer && i_cmd == rmsn_pkg::CMD_ACCUM && acc_end) begin
                    n_state = rmsn_pkg::ST_LOAD_MEAN;
                end
            end
            rmsn_pkg::ST_LOAD_MEAN:  n_state = rmsn_pkg::ST_DIV_MEAN;
            rmsn_pkg::ST_DIV_MEAN: begin
                if (r_cnt == '0) n_state = rmsn_pkg::ST_LOAD_RECIP;
            end
            rmsn_pkg::ST_LOAD_RECIP: begin
                n_state = i_stat.ms_zero ? rmsn_pkg::ST_IDLE : rmsn_pkg::ST_DIV_RECIP;
            end
            rmsn_pkg::ST_DIV_RECIP: begin
                if (r_cnt == '0) n_state = rmsn_pkg::ST_LOAD_SQRT;
            end
            rmsn_pkg::ST_LOAD_SQRT:  n_state = rmsn_pkg::ST_SQRT;
            rmsn_pkg::ST_SQRT: begin
                if (r_cnt == '0) n_state = rmsn_pkg::ST_SCALE;
            end
            rmsn_pkg::ST_SCALE:      n_state = rmsn_pkg::ST_IDLE;
            default:                 n_state = rmsn_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        n_acc_cnt  = r_acc_cnt;
        n_norm_cnt = r_norm_cnt;
        n_cnt      = r_cnt - 6'd1;
        unique case (r_state)
            rmsn_pkg::ST_IDLE: begin
                if (xfer && i_cmd == rmsn_pkg::CMD_ACCUM) begin
                    o_cmd.accum = 1'b1;
                    n_acc_cnt   = acc_end ? '0 : r_acc_cnt + 13'd1;
                end
                if (xfer && i_cmd == rmsn_pkg::CMD_NORM) begin
                    o_cmd.norm = 1'b1;
                    o_cmd.last = norm_end;
                    n_norm_cnt = norm_end ? '0 : r_norm_cnt + 13'd1;
                end
            end
            rmsn_pkg::ST_LOAD_MEAN: begin
                o_cmd.load_mean = 1'b1;
                n_cnt           = rmsn_pkg::DIV_STEPS_M1;
            end
            rmsn_pkg::ST_DIV_MEAN,
            rmsn_pkg::ST_DIV_RECIP: o_cmd.div_step = 1'b1;
            rmsn_pkg::ST_LOAD_RECIP: begin
                o_cmd.load_recip = !i_stat.ms_zero;
                o_cmd.sat_scale  = i_stat.ms_zero;
                n_cnt            = rmsn_pkg::DIV_STEPS_M1;
            end
            rmsn_pkg::ST_LOAD_SQRT: begin
                o_cmd.load_sqrt = 1'b1;
                n_cnt           = rmsn_pkg::SQRT_STEPS_M1;
            end
            rmsn_pkg::ST_SQRT:  o_cmd.sqrt_step  = 1'b1;
            rmsn_pkg::ST_SCALE: o_cmd.load_scale = 1'b1;
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= rmsn_pkg::ST_IDLE;
            r_acc_cnt  <= '0;
            r_norm_cnt <= '0;
            r_cnt      <= '0;
        end else begin
            r_state    <= n_state;
            r_acc_cnt  <= n_acc_cnt;
            r_norm_cnt <= n_norm_cnt;
            r_cnt      <= n_cnt;
        end
    end
endmodule

// File: src/rmsn_dp.sv
// rmsn_dp: datapath of the RMS normalizer; square sum, shared restoring
// divider, digit square root, scale multiply and output register. Uses rmsn_pkg.
`timescale 1ns / 1ps
module rmsn_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  rmsn_pkg::t_cmd                        i_cmd,
    input  logic signed [rmsn_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic [rmsn_pkg::LEN_W-1:0]            i_len,
    input  logic [rmsn_pkg::EPS_W-1:0]            i_eps,
    input  logic                                  i_out_ready,
    output rmsn_pkg::t_stat                       o_stat,
    output logic                                  o_out_valid,
    output logic signed [rmsn_pkg::SAMPLE_W-1:0]  o_out_value,
    output logic                                  o_out_last
);
    logic [rmsn_pkg::SUM_W-1:0]   r_sum;
    logic [rmsn_pkg::DIVD_W-1:0]  r_quo;
    logic [rmsn_pkg::REM_W-1:0]   r_rem;
    logic [rmsn_pkg::MS_W-1:0]    r_dvs;
    logic [rmsn_pkg::DIVD_W:0]    r_rad;
    logic [rmsn_pkg::ROOT_W-1:0]  r_root;
    logic [rmsn_pkg::SREM_W-1:0]  r_srem;
    logic [rmsn_pkg::SCALE_W-1:0] r_scale;
    logic                         r_out_valid;
    logic signed [rmsn_pkg::SAMPLE_W-1:0] r_out_value;
    logic                         r_out_last;

    logic signed [31:0]           sq;
    logic [rmsn_pkg::SUM_W:0]     sum_add;
    logic [rmsn_pkg::MS_W-1:0]    ms;
    logic [rmsn_pkg::REM_W:0]     div_sh;
    logic                         div_ge;
    logic [rmsn_pkg::SREM_W+1:0]  sq_sh;
    logic [rmsn_pkg::SREM_W+1:0]  sq_trial;
    logic                         sq_ge;
    logic [rmsn_pkg::ROOT_W:0]    root_inc;
    logic signed [44:0]           prod;
    logic signed [44:0]           prod_r;
    logic signed [28:0]           shifted;
    logic signed [rmsn_pkg::SAMPLE_W-1:0] sat_val;

    assign sq      = i_sample * i_sample;
    assign sum_add = {1'b0, r_sum} + {12'd0, sq};
    assign ms      = {1'b0, r_quo[rmsn_pkg::SUM_W-1:0]} + {28'd0, i_eps};

    assign div_sh = {r_rem, r_quo[rmsn_pkg::DIVD_W-1]};
    assign div_ge = div_sh >= {2'b00, r_dvs};

    assign sq_sh    = {r_srem, r_rad[rmsn_pkg::DIVD_W:rmsn_pkg::DIVD_W-1]};
    assign sq_trial = {2'b00, r_root, 2'b01};
    assign sq_ge    = sq_sh >= sq_trial;
    assign root_inc = {1'b0, r_root} + 31'd1;

    assign prod    = i_sample * $signed({1'b0, r_scale});
    assign prod_r  = prod + 45'sd32768;
    assign shifted = prod_r[44:16];
    always_comb begin
        if (shifted > 29'sd32767)       sat_val = 16'sh7FFF;
        else if (shifted < -29'sd32768) sat_val = -16'sh8000;
        else                            sat_val = shifted[15:0];
    end

    assign o_stat.ms_zero  = (ms == '0);
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_scale     <= rmsn_pkg::SCALE_ONE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accum) begin
                r_sum <= sum_add[rmsn_pkg::SUM_W] ? rmsn_pkg::SUM_MAX
                                                  : sum_add[rmsn_pkg::SUM_W-1:0];
            end else if (i_cmd.load_mean) begin
                r_sum <= '0;
            end
            if (i_cmd.sat_scale) begin
                r_scale <= rmsn_pkg::SCALE_MAX;
            end else if (i_cmd.load_scale) begin
                r_scale <= (root_inc[rmsn_pkg::ROOT_W:rmsn_pkg::SCALE_W+1] != '0)
                           ? rmsn_pkg::SCALE_MAX : root_inc[rmsn_pkg::SCALE_W:1];
            end
            if (i_cmd.norm) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.norm) begin
            r_out_value <= sat_val;
            r_out_last  <= i_cmd.last;
        end
        if (i_cmd.load_mean) begin
            r_quo <= {16'd0, r_sum};
            r_dvs <= {31'd0, i_len};
            r_rem <= '0;
        end else if (i_cmd.load_recip) begin
            r_quo <= {1'b1, {(rmsn_pkg::DIVD_W-1){1'b0}}};
            r_dvs <= ms;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[rmsn_pkg::DIVD_W-2:0], div_ge};
            r_rem <= div_ge ? div_sh[rmsn_pkg::REM_W-1:0] - {1'b0, r_dvs}
                            : div_sh[rmsn_pkg::REM_W-1:0];
        end
        if (i_cmd.load_sqrt) begin
            r_rad  <= {1'b0, r_quo};
            r_root <= '0;
            r_srem <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_rad  <= {r_rad[rmsn_pkg::DIVD_W-2:0], 2'b00};
            r_root <= {r_root[rmsn_pkg::ROOT_W-2:0], sq_ge};
            r_srem <= sq_ge ? (sq_sh[rmsn_pkg::SREM_W-1:0] - sq_trial[rmsn_pkg::SREM_W-1:0])
                            : sq_sh[rmsn_pkg::SREM_W-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_value = r_out_value;
    assign o_out_last  = r_out_last;
endmodule
